// File: sv/lpvh_pkg.sv
// Shared types and constants of the leaf-peeling vertex height unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lpvh_pkg;

    // Capacity of the vertex and edge stores.
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 32;

    // Field widths fixed by the item format.
    localparam int VID_W  = 5;
    localparam int HGT_W  = 6;
    localparam int CFG_W  = 6;
    localparam int DEG_W  = 7;

    // Derived widths of counters and indexes.
    localparam int EID_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);

    // Input command codes carried in tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Result kinds carried in tuser.
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

    // Configuration register indexes.
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EXT_LIMIT    = 1'b1;

    // Reset value of the exterior height limit.
    localparam logic [CFG_W-1:0] EXT_LIMIT_RESET = CFG_W'(2);

    // Height shown for a vertex that was never peeled.
    localparam logic [HGT_W-1:0] HEIGHT_NONE = {HGT_W{1'b1}};

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic             finish;
        logic [VID_W-1:0] end_a;
        logic [VID_W-1:0] end_b;
    } t_cmd;

    // One stored edge.
    typedef struct packed {
        logic [VID_W-1:0] end_a;
        logic [VID_W-1:0] end_b;
    } t_edge;

    // One result item.
    typedef struct packed {
        logic             kind;
        logic [VID_W-1:0] item_index;
        logic [HGT_W-1:0] height;
        logic             exterior;
        logic             last;
    } t_result;

endpackage

// File: sv/lpvh_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on lpvh_pkg.
module lpvh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // [4:0] end_a, [9:5] end_b, rest zero
    input  logic                s_axis_tuser,  // [0] cmd
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output lpvh_pkg::t_cmd      o_cmd
);

    lpvh_pkg::t_cmd                  r_q [lpvh_pkg::QUEUE_DEPTH];
    logic [lpvh_pkg::QPTR_W-1:0]     r_wr;
    logic [lpvh_pkg::QPTR_W-1:0]     r_rd;
    logic [lpvh_pkg::QCNT_W-1:0]     r_count;
    lpvh_pkg::t_cmd                  w_cmd;
    logic                            w_push;
    logic                            w_pop;

    // Classify the incoming item.
    always_comb begin
        w_cmd.finish = (s_axis_tuser == lpvh_pkg::CMD_FINISH);
        w_cmd.end_a  = s_axis_tdata[lpvh_pkg::VID_W-1:0];
        w_cmd.end_b  = s_axis_tdata[2*lpvh_pkg::VID_W-1:lpvh_pkg::VID_W];
    end

    assign s_axis_tready = (r_count != lpvh_pkg::QCNT_W'(lpvh_pkg::QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != '0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_q[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == lpvh_pkg::QPTR_W'(lpvh_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == lpvh_pkg::QPTR_W'(lpvh_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            r_count <= r_count + lpvh_pkg::QCNT_W'(w_push) - lpvh_pkg::QCNT_W'(w_pop);
        end
    end

endmodule

// File: sv/lpvh_back.sv
// Back end: stores edges, peels the graph in rounds and emits the results.
// Depends on lpvh_pkg.
module lpvh_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [lpvh_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  lpvh_pkg::t_cmd                    i_cmd,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output lpvh_pkg::t_result                 o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEG   = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_LOWER = 3'd3;
    localparam logic [2:0] S_VOUT  = 3'd4;
    localparam logic [2:0] S_EOUT  = 3'd5;

    localparam int NV = lpvh_pkg::MAX_VERTICES;

    logic [2:0]                        r_state;
    lpvh_pkg::t_edge                   r_edge_mem [lpvh_pkg::MAX_EDGES];
    logic [lpvh_pkg::ECNT_W-1:0]       r_edge_total;
    logic [lpvh_pkg::DEG_W-1:0]        r_deg [NV];
    logic [lpvh_pkg::HGT_W-1:0]        r_height [NV];
    logic [NV-1:0]                     r_assigned;
    logic [NV-1:0]                     r_peel;
    logic [lpvh_pkg::HGT_W-1:0]        r_round;
    logic [lpvh_pkg::ECNT_W-1:0]       r_eptr;
    logic [lpvh_pkg::VCNT_W-1:0]       r_vptr;
    logic [lpvh_pkg::CFG_W-1:0]        r_vcount;
    logic [lpvh_pkg::CFG_W-1:0]        r_limit;
    lpvh_pkg::t_result                 r_out;
    logic                              r_out_valid;
    logic                              n_out_valid;

    logic [lpvh_pkg::VCNT_W-1:0]       w_n;
    lpvh_pkg::t_edge                   w_edge;
    logic                              w_in_range;
    logic                              w_edge_done;
    logic [NV-1:0]                     w_peel_now;
    logic [NV-1:0]                     w_ext;
    logic                              w_out_free;
    logic [NV-1:0]                     w_vsel_a;
    logic [NV-1:0]                     w_vsel_b;

    // Effective vertex count, clipped to the store size.
    assign w_n = (r_vcount > lpvh_pkg::CFG_W'(NV)) ?
                 lpvh_pkg::VCNT_W'(NV) : lpvh_pkg::VCNT_W'(r_vcount);

    // Edge under the scan pointer and whether both ends are live vertices.
    assign w_edge      = r_edge_mem[r_eptr[lpvh_pkg::EID_W-1:0]];
    assign w_in_range  = (lpvh_pkg::VCNT_W'(w_edge.end_a) < w_n) &&
                         (lpvh_pkg::VCNT_W'(w_edge.end_b) < w_n);
    assign w_edge_done = (r_eptr == r_edge_total);
    assign w_out_free  = !r_out_valid || i_res_ready;

    // Per-vertex peel candidates, exterior flags and endpoint decode.
    always_comb begin
        for (int v = 0; v < NV; v++) begin
            w_peel_now[v] = (lpvh_pkg::VCNT_W'(v) < w_n) && !r_assigned[v] &&
                            (r_deg[v] <= lpvh_pkg::DEG_W'(1));
            w_ext[v]      = r_assigned[v] &&
                            (lpvh_pkg::CFG_W'(r_height[v]) < r_limit);
            w_vsel_a[v]   = (w_edge.end_a == lpvh_pkg::VID_W'(v));
            w_vsel_b[v]   = (w_edge.end_b == lpvh_pkg::VID_W'(v));
        end
    end

    // Output valid: cleared when taken, set when a new result is loaded.
    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        if (w_out_free && ((r_state == S_VOUT && r_vptr != w_n) ||
                           (r_state == S_EOUT && !w_edge_done))) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_limit  <= lpvh_pkg::EXT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpvh_pkg::REG_VERTEX_COUNT: r_vcount <= i_cfg_data;
                lpvh_pkg::REG_EXT_LIMIT:    r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge store writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && !i_cmd.finish &&
            r_edge_total < lpvh_pkg::ECNT_W'(lpvh_pkg::MAX_EDGES)) begin
            r_edge_mem[r_edge_total[lpvh_pkg::EID_W-1:0]] <= '{end_a: i_cmd.end_a,
                                                              end_b: i_cmd.end_b};
        end
    end

    // Remaining degree: counted up from the edges, lowered by each round's peel.
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < NV; v++) begin
            if (r_state == S_IDLE && i_cmd_valid && i_cmd.finish) begin
                r_deg[v] <= '0;
            end else if (r_state == S_DEG && !w_edge_done && w_in_range) begin
                r_deg[v] <= r_deg[v] + lpvh_pkg::DEG_W'(w_vsel_a[v]) +
                            lpvh_pkg::DEG_W'(w_vsel_b[v]);
            end else if (r_state == S_LOWER && !w_edge_done && w_in_range) begin
                if (r_deg[v] > lpvh_pkg::DEG_W'(w_vsel_b[v] && r_peel[w_edge.end_a]) +
                               lpvh_pkg::DEG_W'(w_vsel_a[v] && r_peel[w_edge.end_b])) begin
                    r_deg[v] <= r_deg[v]
                              - lpvh_pkg::DEG_W'(w_vsel_b[v] && r_peel[w_edge.end_a])
                              - lpvh_pkg::DEG_W'(w_vsel_a[v] && r_peel[w_edge.end_b]);
                end else begin
                    r_deg[v] <= '0;
                end
            end
        end
    end

    // Heights of the vertices peeled in the current round.
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < NV; v++) begin
            if (r_state == S_MARK && w_peel_now[v]) begin
                r_height[v] <= r_round;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_state == S_VOUT && r_vptr != w_n) begin
                r_out.kind       <= lpvh_pkg::KIND_VERTEX;
                r_out.item_index <= r_vptr[lpvh_pkg::VID_W-1:0];
                r_out.height     <= r_assigned[r_vptr[lpvh_pkg::VID_W-1:0]] ?
                                    r_height[r_vptr[lpvh_pkg::VID_W-1:0]] :
                                    lpvh_pkg::HEIGHT_NONE;
                r_out.exterior   <= w_ext[r_vptr[lpvh_pkg::VID_W-1:0]];
                r_out.last       <= (r_vptr + 1'b1 == w_n) && (r_edge_total == '0);
            end else if (r_state == S_EOUT && !w_edge_done) begin
                r_out.kind       <= lpvh_pkg::KIND_EDGE;
                r_out.item_index <= lpvh_pkg::VID_W'(r_eptr);
                r_out.height     <= '0;
                r_out.exterior   <= !(w_in_range && !w_ext[w_edge.end_a] &&
                                      !w_ext[w_edge.end_b]);
                r_out.last       <= (r_eptr + 1'b1 == r_edge_total);
            end
        end
    end

    // Sequencer for loading, peeling and emitting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edge_total <= '0;
            r_assigned   <= '0;
            r_peel       <= '0;
            r_round      <= '0;
            r_eptr       <= '0;
            r_vptr       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.finish) begin
                            r_assigned <= '0;
                            r_eptr     <= '0;
                            r_state    <= S_DEG;
                        end else if (r_edge_total <
                                     lpvh_pkg::ECNT_W'(lpvh_pkg::MAX_EDGES)) begin
                            r_edge_total <= r_edge_total + 1'b1;
                        end
                    end
                end
                S_DEG: begin
                    if (w_edge_done) begin
                        r_round <= '0;
                        r_state <= S_MARK;
                    end else begin
                        r_eptr <= r_eptr + 1'b1;
                    end
                end
                S_MARK: begin
                    if (w_peel_now != '0) begin
                        r_assigned <= r_assigned | w_peel_now;
                        r_peel     <= w_peel_now;
                        r_round    <= r_round + 1'b1;
                        r_eptr     <= '0;
                        r_state    <= S_LOWER;
                    end else begin
                        r_vptr  <= '0;
                        r_eptr  <= '0;
                        r_state <= S_VOUT;
                    end
                end
                S_LOWER: begin
                    if (w_edge_done) begin
                        r_state <= S_MARK;
                    end else begin
                        r_eptr <= r_eptr + 1'b1;
                    end
                end
                S_VOUT: begin
                    if (r_vptr == w_n) begin
                        r_state <= S_EOUT;
                    end else if (w_out_free) begin
                        r_vptr <= r_vptr + 1'b1;
                    end
                end
                S_EOUT: begin
                    if (w_edge_done) begin
                        r_edge_total <= '0;
                        r_state      <= S_IDLE;
                    end else if (w_out_free) begin
                        r_eptr <= r_eptr + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A lowering pass always follows a round that peeled something.
    a_lower_has_peel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOWER) |-> (r_peel != '0))
        else $error("lowering pass without peeled vertices");

    // The edge count never exceeds the store.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= lpvh_pkg::ECNT_W'(lpvh_pkg::MAX_EDGES))
        else $error("edge count beyond capacity");

    // Every round peels a vertex, so rounds stay within the vertex count.
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lpvh_pkg::CFG_W'(r_round) <= lpvh_pkg::CFG_W'(NV))
        else $error("peeling round count beyond vertex count");

    // The final result of a run is followed by a return to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT && w_edge_done) |=> (r_state == S_IDLE && r_edge_total == '0))
        else $error("run did not end cleanly");

endmodule

// File: sv/leaf_peeling_vertex_height_unit.sv
// Top level of the leaf-peeling vertex height unit.
// Depends on lpvh_pkg, lpvh_front and lpvh_back.
//
// Usage:
// Input items arrive on the s_axis channel. tuser is the command: a load item
// stores the edge in tdata (end_a, end_b); a finish item peels the loaded graph.
// Result items leave on m_axis: tuser is the kind (vertex or edge), tlast marks
// the final result of a run. Each vertex below vertex_count gives one result
// (index, height, exterior), then each stored edge gives one (load order, exterior).
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// While idle, the back end takes load items as they come. A finish item
// first counts degrees in one scan of the stored edges, then runs R peel
// rounds (each round scans all E stored edges once), then emits the N + E
// results; it takes no new item until the run is back in idle.
// A two-entry queue lets the front keep accepting items while the back is busy.
// Reset clears the edge count, the peel flags and the command queue; vertex_count
// resets to zero and the exterior limit to two. When the receiver stalls, the
// output register holds its item and the back end waits.
module leaf_peeling_vertex_height_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [lpvh_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [4:0] end_a, [9:5] end_b
    input  logic                        s_axis_tuser,  // [0] cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // [4:0] item_index, [10:5] height,
                                                       // [11] exterior
    output logic                        m_axis_tuser,  // [0] kind
    output logic                        m_axis_tlast
);

    lpvh_pkg::t_cmd     w_cmd;
    logic               w_cmd_valid;
    logic               w_cmd_ready;
    lpvh_pkg::t_result  w_res;

    // Front end with the command queue.
    lpvh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // Back end that stores, peels and emits.
    lpvh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd        (w_cmd),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (w_res)
    );

    // Pack the result fields onto the stream.
    assign m_axis_tdata = {4'b0000, w_res.exterior, w_res.height, w_res.item_index};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule
